// ===== sv/address_range_to_slot_lookup_top_macros.svh =====
// Assertion macros shared by the address range lookup RTL.
`ifndef ADDRESS_RANGE_TO_SLOT_LOOKUP_TOP_MACROS_SVH
`define ADDRESS_RANGE_TO_SLOT_LOOKUP_TOP_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define ARSL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ARSL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define ARSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/arsl_pkg.sv =====
// ----------------------------------------------------------------------------
// Address range lookup package
// Shared widths, codes, the table entry layout and the controller states.
// ----------------------------------------------------------------------------
package arsl_pkg;

  // Default table depth.
  localparam int DEF_MAX_RANGES = 256;

  // Field widths.
  localparam int ACTION_W = 2;
  localparam int ADDR_W   = 64;
  localparam int COUNT_W  = 24;
  localparam int SHIFT_W  = 5;
  localparam int HANDLE_W = 32;
  localparam int LEN_W    = 54;
  localparam int INDEX_W  = 8;
  localparam int ECOUNT_W = 9;

  // Largest slot shift that an append may carry.
  localparam logic [SHIFT_W-1:0] MAX_SHIFT = 5'd30;

  // Request codes.
  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // One stored range.
  typedef struct packed {
    logic [ADDR_W-1:0]   start;
    logic [LEN_W-1:0]    length;
    logic [SHIFT_W-1:0]  shift;
    logic [HANDLE_W-1:0] first;
  } entry_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_DONE
  } state_t;

endpackage

// ===== sv/arsl_ram.sv =====
// ----------------------------------------------------------------------------
// Address range lookup RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module arsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/address_range_to_slot_lookup_top.sv =====
// ----------------------------------------------------------------------------
// Address range to slot lookup
// Append and clear requests are answered from idle; the result is registered.
// A lookup scans the entry RAM from entry 0, one read per cycle, until an entry
// matches (ST_CALC then forms the handle) or the last stored entry misses;
// ST_DONE waits for a free output. An empty table is answered from idle. One
// request is in flight at a time. Reset empties the table at once; the RAM is never cleared.
// ----------------------------------------------------------------------------
module address_range_to_slot_lookup_top #(
  parameter int MAX_RANGES = arsl_pkg::DEF_MAX_RANGES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [arsl_pkg::ACTION_W-1:0] in_action,
  input  logic [arsl_pkg::ADDR_W-1:0]   in_address,
  input  logic [arsl_pkg::ADDR_W-1:0]   in_range_base,
  input  logic [arsl_pkg::COUNT_W-1:0]  in_slot_count,
  input  logic [arsl_pkg::SHIFT_W-1:0]  in_slot_shift,
  input  logic [arsl_pkg::HANDLE_W-1:0] in_first_handle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [arsl_pkg::HANDLE_W-1:0] out_slot_handle,
  output logic [arsl_pkg::INDEX_W-1:0]  out_range_index,
  output logic                          out_accepted,
  output logic [arsl_pkg::ECOUNT_W-1:0] out_entry_count
);
  import arsl_pkg::*;

  `include "address_range_to_slot_lookup_top_macros.svh"

  localparam int IDX_W = $clog2(MAX_RANGES);
  localparam int CNT_W = $clog2(MAX_RANGES + 1);

  // Control state.
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;

  // Lookup working registers.
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic                hit_r, hit_nxt;
  logic [LEN_W-1:0]    off_r, off_nxt;
  logic [SHIFT_W-1:0]  shift_r, shift_nxt;
  logic [HANDLE_W-1:0] first_r, first_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;

  // Output register.
  logic                out_valid_r, out_load;
  logic                out_hit_r, out_hit_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic [INDEX_W-1:0]  out_index_r, out_index_nxt;
  logic                out_acc_r, out_acc_nxt;
  logic [ECOUNT_W-1:0] out_count_r, out_count_nxt;

  // Entry RAM ports.
  logic             wr_en, rd_en;
  entry_t           wr_entry, rd_entry;
  logic [IDX_W-1:0] rd_addr;

  // Scan compare terms.
  logic [ADDR_W-1:0] cmp_off;
  logic              cmp_match;
  logic              cmp_last;

  logic    out_free;
  logic    accept;
  action_t action;

  arsl_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_RANGES)
  ) u_entry_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count_r[IDX_W-1:0]),
    .wr_data(wr_entry),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_entry)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign action   = action_t'(in_action);

  // Entry built from an append request.
  assign wr_entry.start  = in_range_base;
  assign wr_entry.length = LEN_W'(in_slot_count) << in_slot_shift;
  assign wr_entry.shift  = in_slot_shift;
  assign wr_entry.first  = in_first_handle;

  // Offset test against the entry read in the previous cycle.
  assign cmp_off   = addr_r - rd_entry.start;
  assign cmp_match = (cmp_off[ADDR_W-1:LEN_W] == '0) && (cmp_off[LEN_W-1:0] < rd_entry.length);
  assign cmp_last  = (CNT_W'(cmp_idx_r) + CNT_W'(1)) == count_r;

  // Next state and datapath control.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cmp_idx_nxt    = cmp_idx_r;
    addr_nxt       = addr_r;
    hit_nxt        = hit_r;
    off_nxt        = off_r;
    shift_nxt      = shift_r;
    first_nxt      = first_r;
    handle_nxt     = handle_r;
    idx_nxt        = idx_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = IDX_W'(cmp_idx_r + IDX_W'(1));
    out_load       = 1'b0;
    out_hit_nxt    = 1'b0;
    out_handle_nxt = '0;
    out_index_nxt  = '0;
    out_acc_nxt    = 1'b0;
    out_count_nxt  = ECOUNT_W'(count_r);

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (action)
            ACT_APPEND: begin
              out_load = 1'b1;
              if ((count_r < CNT_W'(MAX_RANGES)) && (in_slot_count != '0)
                  && (in_slot_shift <= MAX_SHIFT)) begin
                wr_en         = 1'b1;
                count_nxt     = count_r + CNT_W'(1);
                out_acc_nxt   = 1'b1;
                out_count_nxt = ECOUNT_W'(count_nxt);
              end
            end
            ACT_LOOKUP: begin
              if (count_r == '0) begin
                out_load = 1'b1;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = '0;
                cmp_idx_nxt = '0;
                addr_nxt    = in_address;
                state_nxt   = ST_SCAN;
              end
            end
            ACT_CLEAR: begin
              out_load      = 1'b1;
              count_nxt     = '0;
              out_count_nxt = '0;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (cmp_match) begin
          hit_nxt   = 1'b1;
          off_nxt   = cmp_off[LEN_W-1:0];
          shift_nxt = rd_entry.shift;
          first_nxt = rd_entry.first;
          idx_nxt   = cmp_idx_r;
          state_nxt = ST_CALC;
        end else if (cmp_last) begin
          hit_nxt    = 1'b0;
          handle_nxt = '0;
          idx_nxt    = '0;
          state_nxt  = ST_DONE;
        end else begin
          rd_en       = 1'b1;
          cmp_idx_nxt = IDX_W'(cmp_idx_r + IDX_W'(1));
        end
      end
      ST_CALC: begin
        handle_nxt = first_r + HANDLE_W'(off_r >> shift_r);
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_hit_nxt    = hit_r;
          out_handle_nxt = handle_r;
          out_index_nxt  = INDEX_W'(idx_r);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    addr_r    <= addr_nxt;
    hit_r     <= hit_nxt;
    off_r     <= off_nxt;
    shift_r   <= shift_nxt;
    first_r   <= first_nxt;
    handle_r  <= handle_nxt;
    idx_r     <= idx_nxt;
    if (out_load) begin
      out_hit_r    <= out_hit_nxt;
      out_handle_r <= out_handle_nxt;
      out_index_r  <= out_index_nxt;
      out_acc_r    <= out_acc_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_slot_handle = out_handle_r;
  assign out_range_index = out_index_r;
  assign out_accepted    = out_acc_r;
  assign out_entry_count = out_count_r;

  // The fill count never passes the table depth.
  `ARSL_ASSERT(a_count_bound, count_r <= CNT_W'(MAX_RANGES), "entry count above table depth")
  // The scan only visits stored entries.
  `ARSL_ASSERT_IMPL(a_scan_in_table, state_r == ST_SCAN, CNT_W'(cmp_idx_r) < count_r, "scan index beyond stored entries")
  // The table does not change while a lookup is in progress.
  `ARSL_ASSERT_NEXT(a_count_held, state_r != ST_IDLE, $stable(count_r), "entry count changed during lookup")
  // A stored append and a lookup hit never appear in the same result.
  `ARSL_ASSERT_IMPL(a_hit_or_acc, out_valid_r, !(out_hit_r && out_acc_r), "hit and accepted both set")
  // A missed lookup carries zero handle and index.
  `ARSL_ASSERT_IMPL(a_miss_zero, out_valid_r && !out_hit_r, (out_handle_r == '0) && (out_index_r == '0), "miss result carries nonzero fields")

endmodule
